// File: rtl/tcpo_pkg.sv
package tcpo_pkg;

  localparam int NUM_CHAN = 3;
  localparam int TIME_W   = 32;
  localparam int LEN_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic [1:0] OP_PULSE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_FORCE = 2'd2;

  // Command codes
  localparam logic [1:0] CMD_NOP = 2'd0;
  localparam logic [1:0] CMD_ON  = 2'd1;
  localparam logic [1:0] CMD_OFF = 2'd2;
  localparam logic [1:0] CMD_ALM = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ON_POL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_POL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_POL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd5;

  // Per-channel control for one executed word
  typedef struct packed {
    logic              start;
    logic              tick;
    logic              stop;
    logic [TIME_W-1:0] now;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  timeout;
  } tcpo_chan_ctl_t;

endpackage

// File: rtl/tcpo_chan.sv
module tcpo_chan
  import tcpo_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  tcpo_chan_ctl_t    ctl,
  output logic              active_next,
  output logic [TIME_W-1:0] total_next
);

  logic              active;
  logic [TIME_W-1:0] start;
  logic [TIME_W-1:0] start_next;
  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  length_next;
  logic [TIME_W-1:0] total;
  logic [TIME_W-1:0] elapsed;
  logic              expired;

  // Elapsed time wraps modulo 2^32
  assign elapsed = ctl.now - start;
  assign expired = (elapsed >= {{(TIME_W-LEN_W){1'b0}}, length}) ||
                   (elapsed >= {{(TIME_W-LEN_W){1'b0}}, ctl.timeout});

  always_comb begin
    active_next = active;
    start_next  = start;
    length_next = length;
    total_next  = total;
    if (ctl.start) begin
      active_next = 1'b1;
      start_next  = ctl.now;
      length_next = ctl.length;
      total_next  = total + 1'b1;
    end else if (ctl.tick && active && expired) begin
      active_next = 1'b0;
      length_next = '0;
    end else if (ctl.stop) begin
      active_next = 1'b0;
      length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      start  <= '0;
      length <= '0;
      total  <= '0;
    end else begin
      active <= active_next;
      start  <= start_next;
      length <= length_next;
      total  <= total_next;
    end
  end

endmodule

// File: rtl/three_channel_pulse_output_unit.sv
// Three one-shot pulse channels: motor on, motor off and alarm.
//
// Input channel (in_valid/in_ready) carries one word per item: operation,
// command, pulse_len_ms and now_ms. A pulse word clamps the length between
// min_pulse_ms and max_pulse_ms and starts the named channel; a tick word
// ends channels whose wrapping elapsed time reached their length or the
// hard timeout; a force-off word stops all channels.
// Output channel (out_valid/out_ready) returns exactly one status word per
// input word: accept flag, pin levels, reported flags, last command and time,
// and the three wrapping pulse counters.
//
// A word passes through the input register, then is executed into the result
// register, from which the receiver takes it.
// Throughput: one word per cycle while the receiver keeps up; the channel
// update is one 32-bit subtract and two compares per channel between the
// input and result registers. When the receiver stalls, the result register
// holds, the input register fills, and in_ready drops once both are full.
// Reset clears all channels, counters, last command, pending words, and loads
// the default configuration (active-high pins, 50/1000 ms clamp, 2000 ms cap).
// Configuration writes through cfg_we take effect at the next edge.
module three_channel_pulse_output_unit
  import tcpo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            operation,
  input  logic [1:0]            command,
  input  logic [LEN_W-1:0]      pulse_len_ms,
  input  logic [TIME_W-1:0]     now_ms,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  accepted,
  output logic                  on_pin,
  output logic                  off_pin,
  output logic                  alarm_pin,
  output logic                  on_reported,
  output logic                  off_reported,
  output logic                  alarm_reported,
  output logic [1:0]            last_cmd,
  output logic [TIME_W-1:0]     last_cmd_time,
  output logic [TIME_W-1:0]     on_total,
  output logic [TIME_W-1:0]     off_total,
  output logic [TIME_W-1:0]     alarm_total
);

  // Configuration registers
  logic [NUM_CHAN-1:0] polarity;
  logic [LEN_W-1:0]    min_len;
  logic [LEN_W-1:0]    max_len;
  logic [LEN_W-1:0]    timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      polarity <= '1;
      min_len  <= 16'd50;
      max_len  <= 16'd1000;
      timeout  <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_POL:    polarity[0] <= cfg_data[0];
        REG_OFF_POL:   polarity[1] <= cfg_data[0];
        REG_ALARM_POL: polarity[2] <= cfg_data[0];
        REG_MIN_LEN:   min_len     <= cfg_data;
        REG_MAX_LEN:   max_len     <= cfg_data;
        REG_TIMEOUT:   timeout     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register stage
  logic              s_valid;
  logic [1:0]        s_op;
  logic [1:0]        s_cmd;
  logic [LEN_W-1:0]  s_len;
  logic [TIME_W-1:0] s_now;
  logic              advance;
  logic              exec;

  // Advance whenever the result register is empty or being drained
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s_valid || advance;
  assign exec     = s_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_op  <= operation;
      s_cmd <= command;
      s_len <= pulse_len_ms;
      s_now <= now_ms;
    end
  end

  // Decode and clamp
  logic             is_pulse;
  logic             is_tick;
  logic             is_force;
  logic             refused;
  logic [LEN_W-1:0] bounded;

  assign is_pulse = (s_op == OP_PULSE);
  assign is_tick  = (s_op == OP_TICK);
  assign is_force = (s_op == OP_FORCE);
  assign refused  = is_pulse && (s_cmd == CMD_NOP);

  // When the bounds cross, a length below min_len gets min_len, any other max_len
  assign bounded = (s_len < min_len) ? min_len :
                   (s_len > max_len) ? max_len : s_len;

  // Channels
  tcpo_chan_ctl_t    chan_ctl    [NUM_CHAN];
  logic [NUM_CHAN-1:0] active_next;
  logic [TIME_W-1:0] total_next  [NUM_CHAN];

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    always_comb begin
      chan_ctl[c].start   = exec && is_pulse && (s_cmd == 2'(c + 1));
      chan_ctl[c].tick    = exec && is_tick;
      chan_ctl[c].stop    = exec && is_force;
      chan_ctl[c].now     = s_now;
      chan_ctl[c].length  = bounded;
      chan_ctl[c].timeout = timeout;
    end

    tcpo_chan u_chan (
      .clk         (clk),
      .rst         (rst),
      .ctl         (chan_ctl[c]),
      .active_next (active_next[c]),
      .total_next  (total_next[c])
    );
  end

  // Reported flags and last command
  logic [NUM_CHAN-1:0] reported;
  logic [NUM_CHAN-1:0] reported_next;
  logic [1:0]          cmd_reg;
  logic [1:0]          cmd_reg_next;
  logic [TIME_W-1:0]   cmd_time;
  logic [TIME_W-1:0]   cmd_time_next;

  always_comb begin
    reported_next = reported;
    cmd_reg_next  = cmd_reg;
    cmd_time_next = cmd_time;
    if (exec) begin
      // Refresh flags only on tick or force-off
      if (is_tick) begin
        reported_next = active_next;
      end else if (is_force) begin
        reported_next = '0;
      end
      if (is_pulse && !refused) begin
        cmd_reg_next  = s_cmd;
        cmd_time_next = s_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reported <= '0;
      cmd_reg  <= CMD_NOP;
      cmd_time <= '0;
    end else begin
      reported <= reported_next;
      cmd_reg  <= cmd_reg_next;
      cmd_time <= cmd_time_next;
    end
  end

  // Result register: load on execute, drop valid once taken
  logic [NUM_CHAN-1:0] pin_next;

  // Pin is active XNOR polarity
  assign pin_next = ~(active_next ^ polarity);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      accepted       <= 1'b0;
      on_pin         <= 1'b0;
      off_pin        <= 1'b0;
      alarm_pin      <= 1'b0;
      on_reported    <= 1'b0;
      off_reported   <= 1'b0;
      alarm_reported <= 1'b0;
      last_cmd       <= CMD_NOP;
      last_cmd_time  <= '0;
      on_total       <= '0;
      off_total      <= '0;
      alarm_total    <= '0;
    end else if (exec) begin
      out_valid      <= 1'b1;
      accepted       <= !refused;
      on_pin         <= pin_next[0];
      off_pin        <= pin_next[1];
      alarm_pin      <= pin_next[2];
      on_reported    <= reported_next[0];
      off_reported   <= reported_next[1];
      alarm_reported <= reported_next[2];
      last_cmd       <= cmd_reg_next;
      last_cmd_time  <= cmd_time_next;
      on_total       <= total_next[0];
      off_total      <= total_next[1];
      alarm_total    <= total_next[2];
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/tcpo_checker.sv
module tcpo_checker
  import tcpo_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              accepted,
  input logic [1:0]        last_cmd,
  input logic [TIME_W-1:0] last_cmd_time,
  input logic [TIME_W-1:0] on_total,
  input logic [TIME_W-1:0] off_total,
  input logic [TIME_W-1:0] alarm_total
);

  logic [NUM_CHAN-1:0] bumped;
  logic [TIME_W-1:0]   prev_on_total;
  logic [TIME_W-1:0]   prev_off_total;
  logic [TIME_W-1:0]   prev_alarm_total;

  // Counter values seen at the previous edge
  always_ff @(posedge clk) begin
    prev_on_total    <= on_total;
    prev_off_total   <= off_total;
    prev_alarm_total <= alarm_total;
  end

  assign bumped[0] = (on_total    != prev_on_total);
  assign bumped[1] = (off_total   != prev_off_total);
  assign bumped[2] = (alarm_total != prev_alarm_total);

  // Nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(last_cmd_time) && $stable(on_total))
    else $error("stalled result changed");

  // Counters step by one at most, one channel per word
  a_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (on_total - $past(on_total)) <= 32'd1 &&
                    (off_total - $past(off_total)) <= 32'd1 &&
                    (alarm_total - $past(alarm_total)) <= 32'd1 &&
                    $onehot0(bumped))
    else $error("pulse counter jumped");

  // A counted pulse is accepted and names its channel as last command
  a_bump_cmd: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (bumped != '0) |->
      out_valid && accepted &&
      ((bumped[0] && last_cmd == CMD_ON) || (bumped[1] && last_cmd == CMD_OFF) ||
       (bumped[2] && last_cmd == CMD_ALM)))
    else $error("counter moved without matching command");

endmodule

bind three_channel_pulse_output_unit tcpo_checker u_tcpo_checker (.*);
